FILE: design/slot_range_chunk_splitter_unit_macros.svh
// Assertion macros for the slot range chunk splitter.
// Both macros sample on the rising edge of clk_i.
// SRCS_ASSERT is switched off while rst_ni is low; SRCS_ASSERT_ALWAYS also holds during reset.
`ifndef SLOT_RANGE_CHUNK_SPLITTER_UNIT_MACROS_SVH
`define SLOT_RANGE_CHUNK_SPLITTER_UNIT_MACROS_SVH
`ifndef SYNTH
`define SRCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SRCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SRCS_ASSERT(label, prop, msg)
`define SRCS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: design/srcs_pkg.sv
package srcs_pkg;

  localparam int unsigned SLOT_BYTES  = 512;
  localparam int unsigned CHUNK_BYTES = 32;
  localparam int unsigned MAX_CHUNKS  = 16;
  localparam int unsigned SLOT_ALIGN  = 32;
  localparam int unsigned LAYOUT_ID   = 1;

  // Offsets within a slot, wide enough to hold one chunk past the slot end.
  localparam int unsigned OFF_W       = $clog2(SLOT_BYTES) + 1;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SLOTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_PROFILE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ARG      = 3'd1,
    ST_REGION   = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_FULL     = 3'd4
  } srcs_status_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } srcs_back_state_e;

  // One classified request on its way from the front end to the sequencer.
  typedef struct packed {
    srcs_status_e       status;
    logic               new_plan;
    logic [63:0]        addr;
    logic [OFF_W-1:0]   first_off;
    logic [OFF_W-1:0]   end_off;
    logic [OFF_W-1:0]   chunk0;
    logic [7:0]         tag;
    logic               access;
  } srcs_job_t;

  // Bits lo up to, not including, hi set.
  function automatic logic [31:0] range_mask(logic [5:0] lo, logic [5:0] hi);
    logic [31:0] m;
    for (int i = 0; i < 32; i++) begin
      m[i] = (6'(i) >= lo) && (6'(i) < hi);
    end
    return m;
  endfunction

endpackage

FILE: design/srcs_req_if.sv
interface srcs_req_if;
  logic        valid;
  logic        ready;
  logic        new_plan;
  logic [15:0] slot_index;
  logic [15:0] start_offset;
  logic [15:0] length_bytes;
  logic [7:0]  field_tag;
  logic [1:0]  mode;

  modport source (
    output valid, new_plan, slot_index, start_offset, length_bytes, field_tag, mode,
    input  ready
  );
  modport sink (
    input  valid, new_plan, slot_index, start_offset, length_bytes, field_tag, mode,
    output ready
  );
endinterface

FILE: design/srcs_rsp_if.sv
interface srcs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] chunk_address;
  logic [31:0] cover_mask;
  logic [15:0] cover_offset;
  logic [5:0]  chunk_bytes;
  logic [7:0]  field_out;
  logic        access_out;
  logic        last;

  modport source (
    output valid, status, chunk_address, cover_mask, cover_offset, chunk_bytes,
           field_out, access_out, last,
    input  ready
  );
  modport sink (
    input  valid, status, chunk_address, cover_mask, cover_offset, chunk_bytes,
           field_out, access_out, last,
    output ready
  );
endinterface

FILE: design/srcs_front.sv
module srcs_front
  import srcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] region_base_i,
  input  logic [15:0] region_slots_i,
  input  logic [7:0]  region_profile_i,
  srcs_req_if.sink    req_i,
  output srcs_job_t   job_o,
  output logic        job_valid_o,
  input  logic        job_ready_i
);

  logic        hold_valid_q, hold_valid_d;
  logic        new_plan_q;
  logic [15:0] slot_q;
  logic [15:0] start_q;
  logic [15:0] len_q;
  logic [7:0]  tag_q;
  logic [1:0]  mode_q;

  logic        accept;
  logic        push;
  logic [16:0] end_sum;
  logic [15:0] chunk0;
  logic        arg_bad;
  logic        range_bad;
  logic        region_bad;
  logic [64:0] region_top;
  logic [32:0] slot_span;
  logic [63:0] first_addr;
  srcs_status_e status;

  assign push        = hold_valid_q && job_ready_i;
  assign req_i.ready = !hold_valid_q || job_ready_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (push) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      new_plan_q <= req_i.new_plan;
      slot_q     <= req_i.slot_index;
      start_q    <= req_i.start_offset;
      len_q      <= req_i.length_bytes;
      tag_q      <= req_i.field_tag;
      mode_q     <= req_i.mode;
    end
  end

  // The whole region must fit below 2**64; since the slot lies inside the region,
  // that single carry covers every address the request can produce.
  always_comb begin
    end_sum    = 17'(start_q) + 17'(len_q);
    chunk0     = start_q - (start_q % 16'(CHUNK_BYTES));
    arg_bad    = (len_q == 16'd0) || (mode_q > 2'd1);
    range_bad  = (17'(start_q) >= 17'(SLOT_BYTES)) || (end_sum > 17'(SLOT_BYTES));
    region_bad = (region_profile_i != 8'(LAYOUT_ID)) || (region_slots_i == 16'd0) ||
                 ((region_base_i % 64'(SLOT_ALIGN)) != 64'd0) ||
                 (slot_q >= region_slots_i);
    region_top = {1'b0, region_base_i} + 65'(64'(region_slots_i) * 64'(SLOT_BYTES));
    slot_span  = 33'(33'(slot_q) * 33'(SLOT_BYTES)) + 33'(chunk0);
    first_addr = region_base_i + 64'(slot_span);
    priority if (arg_bad) begin
      status = ST_ARG;
    end else if (range_bad || region_bad) begin
      status = ST_REGION;
    end else if (region_top[64]) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    job_o.status    = status;
    job_o.new_plan  = new_plan_q;
    job_o.addr      = first_addr;
    job_o.first_off = OFF_W'(start_q);
    job_o.end_off   = OFF_W'(end_sum);
    job_o.chunk0    = OFF_W'(chunk0);
    job_o.tag       = tag_q;
    job_o.access    = mode_q[0];
  end

  assign job_valid_o = hold_valid_q;

endmodule

FILE: design/srcs_job_fifo.sv
module srcs_job_fifo
  import srcs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  srcs_job_t wr_job_i,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  output srcs_job_t rd_job_o,
  output logic      rd_valid_o,
  input  logic      rd_ready_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

  srcs_job_t              slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]      fill_q, fill_d;
  logic                   wr_en;
  logic                   rd_en;

  assign wr_ready_o = fill_q != FILL_W'(QUEUE_DEPTH);
  assign rd_valid_o = fill_q != '0;
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_job_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      fill_d = fill_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

FILE: design/srcs_back.sv
module srcs_back
  import srcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  srcs_job_t  job_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  srcs_rsp_if.source rsp_o
);

  srcs_back_state_e state_q, state_d;
  srcs_job_t        job_q;
  logic [OFF_W-1:0] chunk_q;
  logic [63:0]      addr_q;
  logic [CNT_W-1:0] count_q;

  logic             out_valid_q;
  srcs_status_e     out_status_q;
  logic [63:0]      out_addr_q;
  logic [31:0]      out_mask_q;
  logic [15:0]      out_off_q;
  logic [5:0]       out_bytes_q;
  logic [7:0]       out_tag_q;
  logic             out_acc_q;
  logic             out_last_q;

  logic             load;
  logic             emit;
  logic             full;
  logic             chunk_ok;
  logic [OFF_W-1:0] chunk_next;
  logic [OFF_W-1:0] lo;
  logic [OFF_W-1:0] hi;
  srcs_status_e     res_status;
  logic [31:0]      res_mask;
  logic [15:0]      res_off;
  logic [5:0]       res_bytes;
  logic [63:0]      res_addr;
  logic [7:0]       res_tag;
  logic             res_acc;
  logic             res_last;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && res_last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    job_ready_o = 1'b0;
    emit        = 1'b0;
    unique case (state_q)
      BK_IDLE: job_ready_o = 1'b1;
      BK_RUN:  emit = !out_valid_q || rsp_o.ready;
      default: job_ready_o = 1'b0;
    endcase
  end

  assign load = job_ready_o && job_valid_i;

  always_comb begin
    full       = count_q >= CNT_W'(MAX_CHUNKS);
    chunk_next = chunk_q + OFF_W'(CHUNK_BYTES);
    lo         = (job_q.first_off > chunk_q) ? job_q.first_off : chunk_q;
    hi         = (job_q.end_off < chunk_next) ? job_q.end_off : chunk_next;
    chunk_ok   = (job_q.status == ST_OK) && !full;
    res_status = ST_OK;
    res_mask   = '0;
    res_off    = '0;
    res_bytes  = '0;
    res_addr   = '0;
    res_tag    = '0;
    res_acc    = 1'b0;
    res_last   = 1'b1;
    priority if (job_q.status != ST_OK) begin
      res_status = job_q.status;
    end else if (full) begin
      res_status = ST_FULL;
    end else begin
      res_mask  = range_mask(6'(lo - chunk_q), 6'(hi - chunk_q));
      res_off   = 16'(lo);
      res_bytes = 6'(hi - lo);
      res_addr  = addr_q;
      res_tag   = job_q.tag;
      res_acc   = job_q.access;
      res_last  = chunk_next >= job_q.end_off;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load && job_i.new_plan) begin
        count_q <= '0;
      end else if (emit && chunk_ok) begin
        count_q <= count_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q   <= job_i;
      chunk_q <= job_i.chunk0;
      addr_q  <= job_i.addr;
    end else if (emit && chunk_ok) begin
      chunk_q <= chunk_next;
      addr_q  <= addr_q + 64'(CHUNK_BYTES);
    end
    if (emit) begin
      out_status_q <= res_status;
      out_addr_q   <= res_addr;
      out_mask_q   <= res_mask;
      out_off_q    <= res_off;
      out_bytes_q  <= res_bytes;
      out_tag_q    <= res_tag;
      out_acc_q    <= res_acc;
      out_last_q   <= res_last;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.chunk_address = out_addr_q;
  assign rsp_o.cover_mask    = out_mask_q;
  assign rsp_o.cover_offset  = out_off_q;
  assign rsp_o.chunk_bytes   = out_bytes_q;
  assign rsp_o.field_out     = out_tag_q;
  assign rsp_o.access_out    = out_acc_q;
  assign rsp_o.last          = out_last_q;

endmodule

FILE: design/slot_range_chunk_splitter_unit.sv
// Slot range chunk splitter. A request names a slot of the configured region, a byte
// range inside it, a field tag and a read or write mode. The front end registers the
// request and checks from that register the arguments, the slot bounds, the region setup
// and whether the end address of the region still fits in 64 bits; it then hands a
// classified job to a two-entry queue. The sequencer behind the queue takes a job in its
// idle state and then, while its output register is free, gives one result per cycle,
// one for each 32-byte chunk the range touches, each with its address, byte mask,
// offset, byte count and tags; the final one carries last. A failing request gives a
// single result with its status and last set and all other fields zero. A running chunk
// count, cleared by new_plan, caps a plan at MAX_CHUNKS chunks; once it is reached, a
// request ends with one plan-full result after the chunks it already sent. The sequencer
// takes no new job until it has put out the last result of the current one, so it sets
// the sustained rate. Results leave through an output register, so the sequencer stalls
// only while that register holds a result that is not yet taken. The region registers
// are written through the cfg port and must only change while the block is idle.
module slot_range_chunk_splitter_unit
  import srcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_wdata_i,
  srcs_req_if.sink             req_i,
  srcs_rsp_if.source           rsp_o
);

`include "slot_range_chunk_splitter_unit_macros.svh"

  // Region configuration; the user must write it only while no request is in flight, the block does not enforce it.
  logic [63:0] region_base_q;
  logic [15:0] region_slots_q;
  logic [7:0]  region_profile_q;

  // Front end to queue, and queue to sequencer.
  srcs_job_t front_job;
  logic      front_valid;
  logic      front_ready;
  srcs_job_t back_job;
  logic      back_valid;
  logic      back_ready;

  // Writes to an index beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q    <= '0;
      region_slots_q   <= '0;
      region_profile_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_REGION_BASE) begin
        region_base_q <= cfg_wdata_i;
      end
      if (cfg_index_i == CFG_REGION_SLOTS) begin
        region_slots_q <= cfg_wdata_i[15:0];
      end
      if (cfg_index_i == CFG_REGION_PROFILE) begin
        region_profile_q <= cfg_wdata_i[7:0];
      end
    end
  end

  srcs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .region_base_i    (region_base_q),
    .region_slots_i   (region_slots_q),
    .region_profile_i (region_profile_q),
    .req_i            (req_i),
    .job_o            (front_job),
    .job_valid_o      (front_valid),
    .job_ready_i      (front_ready)
  );

  srcs_job_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_job_i   (front_job),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_job_o   (back_job),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  srcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .rsp_o       (rsp_o)
  );

  // Every failing result closes its request.
  `SRCS_ASSERT(a_error_is_last, rsp_o.valid && (rsp_o.status != ST_OK) |-> rsp_o.last, "error result without last")
  // A failing result carries no chunk.
  `SRCS_ASSERT(a_error_is_empty, rsp_o.valid && (rsp_o.status != ST_OK) |-> (rsp_o.cover_mask == 32'd0) && (rsp_o.chunk_bytes == 6'd0), "error result with chunk data")
  // The byte count of a chunk agrees with its mask.
  `SRCS_ASSERT(a_count_matches_mask, rsp_o.valid && (rsp_o.status == ST_OK) |-> ($countones(rsp_o.cover_mask) == int'(rsp_o.chunk_bytes)), "chunk_bytes disagrees with cover_mask")
  // No result is offered while reset is held.
  `SRCS_ASSERT_ALWAYS(a_quiet_in_reset, !rst_ni |-> !rsp_o.valid, "result valid during reset")

endmodule

FILE: test/slot_range_chunk_splitter_unit_checker.sv
// Watches the configuration port and both channels of the chunk splitter. It keeps its own
// copy of the region registers and of the running chunk count, works out the chunk accesses
// that every accepted request must produce, and compares each accepted result against them.
module slot_range_chunk_splitter_unit_checker
  import srcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_wdata_i,
  srcs_req_if                  req_i,
  srcs_rsp_if                  rsp_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam int         MAX_PRINTS = 25;

  typedef struct packed {
    srcs_status_e status;
    logic [63:0]  chunk_address;
    logic [31:0]  cover_mask;
    logic [15:0]  cover_offset;
    logic [5:0]   chunk_bytes;
    logic [7:0]   field_out;
    logic         access_out;
    logic         last;
  } chunk_access_t;

  logic [63:0]   region_base;
  logic [15:0]   region_slots;
  logic [7:0]    region_profile;
  logic [5:0]    chunks_in_plan;
  chunk_access_t planned_q[$];
  int            mismatches;
  int            checked;

  task automatic note_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t: result %0d, %s: got %0h, expected %0h", $realtime, checked, what,
               got, want);
    end
  endtask

  // Pushes every access that one request causes. An error gives a single result with only
  // status and last set; a plan that fills up keeps the chunks already sent.
  function automatic void plan_chunks(input logic clear_plan, input logic [15:0] slot,
                                      input logic [15:0] start, input logic [15:0] len,
                                      input logic [7:0] tag, input logic [1:0] mode);
    chunk_access_t acc;
    logic [65:0]   region_limit;
    logic [65:0]   slot_limit;
    logic [63:0]   slot_addr;
    int unsigned   first_byte;
    int unsigned   end_byte;
    int unsigned   chunk;
    int unsigned   lo;
    int unsigned   hi;
    acc = '0;
    acc.last = 1'b1;
    if (clear_plan) chunks_in_plan = '0;
    first_byte = 32'(start);
    end_byte = 32'(start) + 32'(len);
    if (len == 16'd0 || mode > MODE_WRITE) begin
      acc.status = ST_ARG;
      planned_q.push_back(acc);
      return;
    end
    if (first_byte >= SLOT_BYTES || end_byte > SLOT_BYTES || region_profile != LAYOUT_ID ||
        region_slots == 16'd0 || region_base % SLOT_ALIGN != 0 || slot >= region_slots) begin
      acc.status = ST_REGION;
      planned_q.push_back(acc);
      return;
    end
    region_limit = {2'b00, region_base} + {50'd0, region_slots} * 66'(SLOT_BYTES);
    slot_limit = {2'b00, region_base} + {50'd0, slot} * 66'(SLOT_BYTES) + 66'(SLOT_BYTES);
    if (region_limit[65:64] != 2'b00 || slot_limit > region_limit) begin
      acc.status = ST_OVERFLOW;
      planned_q.push_back(acc);
      return;
    end
    slot_addr = region_base + 64'(slot) * 64'(SLOT_BYTES);
    chunk = first_byte - first_byte % CHUNK_BYTES;
    while (chunk < end_byte) begin
      acc = '0;
      if (chunks_in_plan >= MAX_CHUNKS) begin
        acc.status = ST_FULL;
        acc.last = 1'b1;
        planned_q.push_back(acc);
        return;
      end
      lo = (first_byte > chunk) ? first_byte - chunk : 0;
      hi = (end_byte < chunk + CHUNK_BYTES) ? end_byte - chunk : CHUNK_BYTES;
      acc.status = ST_OK;
      acc.chunk_address = slot_addr + 64'(chunk);
      acc.cover_mask = (32'hffff_ffff >> (32 - (hi - lo))) << lo;
      acc.cover_offset = 16'(chunk + lo);
      acc.chunk_bytes = 6'(hi - lo);
      acc.field_out = tag;
      acc.access_out = mode[0];
      acc.last = (chunk + CHUNK_BYTES >= end_byte);
      planned_q.push_back(acc);
      chunks_in_plan = chunks_in_plan + 6'd1;
      chunk = chunk + CHUNK_BYTES;
    end
  endfunction

  task automatic check_result();
    chunk_access_t want;
    checked++;
    if (planned_q.size() == 0) begin
      note_mismatch("result with nothing outstanding, status", 64'(rsp_i.status), 64'd0);
      return;
    end
    want = planned_q.pop_front();
    if (rsp_i.status != want.status)
      note_mismatch("status", 64'(rsp_i.status), 64'(want.status));
    if (rsp_i.chunk_address != want.chunk_address)
      note_mismatch("chunk_address", rsp_i.chunk_address, want.chunk_address);
    if (rsp_i.cover_mask != want.cover_mask)
      note_mismatch("cover_mask", 64'(rsp_i.cover_mask), 64'(want.cover_mask));
    if (rsp_i.cover_offset != want.cover_offset)
      note_mismatch("cover_offset", 64'(rsp_i.cover_offset), 64'(want.cover_offset));
    if (rsp_i.chunk_bytes != want.chunk_bytes)
      note_mismatch("chunk_bytes", 64'(rsp_i.chunk_bytes), 64'(want.chunk_bytes));
    if (rsp_i.field_out != want.field_out)
      note_mismatch("field_out", 64'(rsp_i.field_out), 64'(want.field_out));
    if (rsp_i.access_out != want.access_out)
      note_mismatch("access_out", 64'(rsp_i.access_out), 64'(want.access_out));
    if (rsp_i.last != want.last)
      note_mismatch("last", 64'(rsp_i.last), 64'(want.last));
  endtask

  // A result is compared before the request of the same edge is planned, since no request
  // can produce a result in the cycle it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base = '0;
      region_slots = '0;
      region_profile = '0;
      chunks_in_plan = '0;
      planned_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) check_result();
      if (req_i.valid && req_i.ready) begin
        plan_chunks(req_i.new_plan, req_i.slot_index, req_i.start_offset,
                    req_i.length_bytes, req_i.field_tag, req_i.mode);
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_REGION_BASE:    region_base = cfg_wdata_i;
          CFG_REGION_SLOTS:   region_slots = cfg_wdata_i[15:0];
          CFG_REGION_PROFILE: region_profile = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
    mismatches_o <= mismatches;
    pending_o <= planned_q.size();
    checked_o <= checked;
  end

endmodule

FILE: test/slot_range_chunk_splitter_unit_test.sv
// Top of the chunk splitter test. This module only makes stimulus and gives the verdict;
// the checker instantiated beside the block does all prediction and comparison.
module slot_range_chunk_splitter_unit_test;
  import srcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_BAD_LO  = 2'd2;
  localparam logic [1:0] MODE_BAD_HI  = 2'd3;
  // Extra wait that covers the input register, the job queue and the output register.
  localparam int         SETTLE_CYCLES = 20;
  localparam int         TIMEOUT_NS    = 5_000_000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_wdata;

  int mismatches;
  int pending;
  int checked;

  // Percent of cycles in which the request side holds back or the result side stalls.
  int unsigned req_idle_pct;
  int unsigned rsp_idle_pct;

  // Slot count currently programmed, used to aim random requests at real slots.
  logic [15:0] cur_slots;
  int          requests_sent;
  int          region_settings;

  srcs_req_if req_ch ();
  srcs_rsp_if rsp_ch ();

  slot_range_chunk_splitter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  slot_range_chunk_splitter_unit_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // The result side decides afresh at every edge whether it takes a result.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  // Hard stop in case the block stops answering.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  // Every task below starts and ends just after a rising edge, so each one drives its
  // signals with exactly one nonblocking assignment per time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drops valid, then waits until the checker has seen every result it expects and the
  // pipeline has had time to empty. The first edge lets the count of the last request land.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The region is only reprogrammed while the block is idle. Bits above the width of the
  // slot count and the profile are filled with noise; the block must ignore them.
  task automatic set_region(input logic [63:0] base, input logic [15:0] slots,
                            input logic [7:0] profile);
    wait_idle();
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_SLOTS, {$urandom, $urandom_range(65535), slots});
    write_reg(CFG_REGION_PROFILE, {$urandom, $urandom_range(16777215), profile});
    cur_slots = slots;
    region_settings++;
  endtask

  // Offers one request, with a random gap in front of it, and holds it until it is taken.
  task automatic send_request(input logic clear_plan, input logic [15:0] slot,
                              input logic [15:0] start, input logic [15:0] len,
                              input logic [7:0] tag, input logic [1:0] mode);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.new_plan <= clear_plan;
    req_ch.slot_index <= slot;
    req_ch.start_offset <= start;
    req_ch.length_bytes <= len;
    req_ch.field_tag <= tag;
    req_ch.mode <= mode;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Most random requests are well formed so that they reach the chunk loop; the new-plan
  // rate lets plans both fill up and get cleared. The rest break one argument on purpose
  // or are plain noise across every bit of every field.
  task automatic random_request();
    int unsigned pick;
    int unsigned room;
    logic [15:0] slot;
    logic [15:0] start;
    logic [15:0] len;
    logic [1:0]  mode;
    logic        clear_plan;
    pick = $urandom_range(99);
    clear_plan = ($urandom_range(99) < 30);
    if (cur_slots == 16'd0) slot = 16'($urandom);
    else if ($urandom_range(9) == 0) slot = cur_slots - 16'd1;
    else slot = 16'($urandom_range(32'(cur_slots) - 1, 0));
    start = 16'($urandom_range(SLOT_BYTES - 1, 0));
    room = SLOT_BYTES - 32'(start);
    if ($urandom_range(99) < 70) len = 16'($urandom_range((room < 64) ? room : 64, 1));
    else len = 16'($urandom_range(room, 1));
    mode = $urandom_range(1) ? MODE_WRITE : MODE_READ;
    if (pick >= 80 && pick < 90) begin
      case ($urandom_range(3))
        0: len = 16'd0;
        1: mode = $urandom_range(1) ? MODE_BAD_HI : MODE_BAD_LO;
        2: len = 16'(room + $urandom_range(64, 1));
        default: slot = cur_slots + 16'($urandom_range(3));
      endcase
    end else if (pick >= 90) begin
      slot = 16'($urandom);
      start = 16'($urandom);
      len = 16'($urandom);
      mode = 2'($urandom);
    end
    send_request(clear_plan, slot, start, len, 8'($urandom), mode);
  endtask

  // Picks a region setting: mostly valid, sometimes right at the top of the address space,
  // sometimes up to eight 32-byte steps past it, misaligned, with a wrong profile or no slots.
  task automatic random_region();
    int unsigned kind;
    logic [63:0] base;
    logic [15:0] slots;
    logic [7:0]  profile;
    kind = $urandom_range(99);
    slots = $urandom_range(1) ? 16'($urandom_range(64, 1)) : 16'($urandom_range(65535, 1));
    base = {$urandom, $urandom} & ~64'h1f;
    profile = 8'(LAYOUT_ID);
    if (kind >= 60 && kind < 70) begin
      base = 64'd0 - 64'(slots) * 64'(SLOT_BYTES);
    end else if (kind >= 70 && kind < 78) begin
      base = 64'd0 - 64'(slots) * 64'(SLOT_BYTES) + 64'(SLOT_ALIGN * $urandom_range(8, 1));
    end else if (kind >= 78 && kind < 86) begin
      base = base | 64'($urandom_range(SLOT_ALIGN - 1, 1));
    end else if (kind >= 86 && kind < 93) begin
      profile = 8'($urandom);
      if (profile == 8'(LAYOUT_ID)) profile = ~profile;
    end else if (kind >= 93) begin
      slots = 16'd0;
    end
    set_region(base, slots, profile);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_REGION_BASE;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.new_plan = 1'b0;
    req_ch.slot_index = '0;
    req_ch.start_offset = '0;
    req_ch.length_bytes = '0;
    req_ch.field_tag = '0;
    req_ch.mode = MODE_READ;
    req_idle_pct = 23;
    rsp_idle_pct = 67;
    cur_slots = '0;
    requests_sent = 0;
    region_settings = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the region is unconfigured, so even a sound request is refused, and a
    // zero length is refused before the region is looked at.
    send_request(1'b1, 16'd0, 16'd0, 16'd32, 8'h00, MODE_READ);
    send_request(1'b0, 16'd0, 16'd0, 16'd0, 8'hff, MODE_WRITE);

    set_region(64'h0000_1000_0000_0000, 16'd16, 8'(LAYOUT_ID));
    // Invalid modes, then ranges that start or end past the slot.
    send_request(1'b0, 16'd3, 16'd0, 16'd8, 8'h5a, MODE_BAD_LO);
    send_request(1'b0, 16'd3, 16'd0, 16'd8, 8'ha5, MODE_BAD_HI);
    send_request(1'b0, 16'd0, 16'd512, 16'd1, 8'h01, MODE_READ);
    send_request(1'b0, 16'hffff, 16'hffff, 16'hffff, 8'hff, MODE_WRITE);
    send_request(1'b0, 16'd0, 16'd500, 16'd13, 8'h02, MODE_READ);
    // A whole slot fills the plan, so the next request gets only the plan-full result.
    send_request(1'b1, 16'd15, 16'd0, 16'd512, 8'hff, MODE_WRITE);
    send_request(1'b0, 16'd0, 16'd0, 16'd1, 8'h10, MODE_READ);
    // Last byte of a slot, a range across one chunk boundary, a slot past the region.
    send_request(1'b1, 16'd0, 16'd511, 16'd1, 8'h00, MODE_READ);
    send_request(1'b0, 16'd7, 16'd31, 16'd2, 8'h3c, MODE_WRITE);
    send_request(1'b0, 16'd16, 16'd0, 16'd4, 8'h11, MODE_READ);
    // Filling the plan to exactly its capacity, then one request more.
    send_request(1'b0, 16'd1, 16'd0, 16'd416, 8'h77, MODE_READ);
    send_request(1'b0, 16'd2, 16'd100, 16'd40, 8'h78, MODE_WRITE);
    // A failing request with new_plan still clears the count.
    send_request(1'b1, 16'd2, 16'd0, 16'd0, 8'h79, MODE_READ);
    send_request(1'b0, 16'd0, 16'd0, 16'd512, 8'h80, MODE_READ);
    // The plan fills in the middle of a request: six chunks go out, then plan full.
    send_request(1'b1, 16'd4, 16'd0, 16'd320, 8'h81, MODE_WRITE);
    send_request(1'b0, 16'd5, 16'd16, 16'd300, 8'h82, MODE_READ);

    // Region ending one chunk below the top of the address space, whose last chunk works,
    // then one ending exactly at the top, whose end address no longer fits and overflows.
    set_region(64'hffff_ffff_ffff_dfe0, 16'd16, 8'(LAYOUT_ID));
    send_request(1'b1, 16'd15, 16'd480, 16'd32, 8'hc3, MODE_WRITE);
    set_region(64'hffff_ffff_ffff_e000, 16'd16, 8'(LAYOUT_ID));
    send_request(1'b1, 16'd0, 16'd0, 16'd8, 8'hc4, MODE_READ);
    // Misaligned base, no slots, wrong profile.
    set_region(64'h0000_0000_0001_0010, 16'd16, 8'(LAYOUT_ID));
    send_request(1'b1, 16'd0, 16'd0, 16'd8, 8'hc5, MODE_READ);
    set_region(64'h0000_0000_0001_0000, 16'd0, 8'(LAYOUT_ID));
    send_request(1'b1, 16'd0, 16'd0, 16'd8, 8'hc6, MODE_READ);
    set_region(64'h0000_0000_0001_0000, 16'd16, 8'hff);
    send_request(1'b1, 16'd0, 16'd0, 16'd8, 8'hc7, MODE_READ);
    // Largest region at address zero: its last slot works, the index after it does not.
    set_region(64'd0, 16'hffff, 8'(LAYOUT_ID));
    send_request(1'b1, 16'hfffe, 16'd0, 16'd512, 8'hc8, MODE_WRITE);
    send_request(1'b1, 16'hffff, 16'd0, 16'd8, 8'hc9, MODE_READ);

    // Random part in three idling patterns, each over several region settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          req_idle_pct = 23;
          rsp_idle_pct = 67;
        end
        1: begin
          req_idle_pct = 67;
          rsp_idle_pct = 23;
        end
        default: begin
          req_idle_pct = 0;
          rsp_idle_pct = 0;
        end
      endcase
      for (int setting = 0; setting < 4; setting++) begin
        random_region();
        repeat (19) random_request();
      end
    end

    wait_idle();
    $display("Covered %0d requests over %0d region settings and three idling patterns.",
             requests_sent, region_settings);
    $display("Checked %0d results field by field against the predicted chunk plans.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
